// ----- design/scsa_pkg.sv -----
// Shared constants, types and codes for the size class slot allocator.
package scsa_pkg;

   localparam int NUM_CLASSES     = 12;
   localparam int SLOTS_PER_CLASS = 256;
   localparam int MIN_SIDE_LOG2   = 3;

   localparam int ACTION_W = 2;
   localparam int SIZE_W   = 15;
   localparam int CLASS_W  = 4;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;

   localparam int WORD_BITS       = 64;
   localparam int WORDS_PER_CLASS = SLOTS_PER_CLASS / WORD_BITS;
   localparam int WORD_IDX_W      = $clog2(WORDS_PER_CLASS);
   localparam int BIT_IDX_W       = $clog2(WORD_BITS);
   localparam int ROWS            = NUM_CLASSES * WORDS_PER_CLASS;
   localparam int ROW_W           = CLASS_W + WORD_IDX_W;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FREE  = 2'd1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_NOT_HELD,
      ST_TOO_LARGE,
      ST_FULL
   } status_type;

   typedef enum logic [2:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_QUERY,
      CMD_TOO_LARGE,
      CMD_FREE_BAD_LEVEL,
      CMD_QUERY_BAD_LEVEL
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_CHECK
   } back_state_type;

   typedef struct packed {
      cmd_kind_type        cmd;
      logic [CLASS_W-1:0]  cls;
      logic [SLOT_W-1:0]   slot;
   } queue_entry_type;

   typedef struct packed {
      status_type          status;
      logic [CLASS_W-1:0]  class_out;
      logic [SLOT_W-1:0]   slot_out;
      logic                grew;
      logic [COUNT_W-1:0]  free_count;
   } result_type;

endpackage

// ----- design/scsa_req_if.sv -----
// Request and response channel interfaces of the size class slot allocator.
interface scsa_req_if;
   import scsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SIZE_W-1:0]   width;
   logic [SIZE_W-1:0]   height;
   logic [CLASS_W-1:0]  level;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, action, width, height, level, slot, input ready);
   modport sink   (input valid, action, width, height, level, slot, output ready);
endinterface

interface scsa_rsp_if;
   import scsa_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [CLASS_W-1:0]  class_out;
   logic [SLOT_W-1:0]   slot_out;
   logic                grew;
   logic [COUNT_W-1:0]  free_count;

   modport source (output valid, status, class_out, slot_out, grew, free_count, input ready);
   modport sink   (input valid, status, class_out, slot_out, grew, free_count, output ready);
endinterface

// ----- design/scsa_front.sv -----
// Front end: accepts request beats, picks the size class and decodes the command.
module scsa_front (
   scsa_req_if.sink                 req_chan,
   output logic                     push_valid,
   input  logic                     push_ready,
   output scsa_pkg::queue_entry_type push_entry
);
   import scsa_pkg::*;

   logic               fits;
   logic [CLASS_W-1:0] fit_class;
   logic               level_ok;

   always_comb begin
      fits      = 1'b0;
      fit_class = '0;
      for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
         if ((32'(req_chan.width) <= (32'd1 << (MIN_SIDE_LOG2 + k))) &&
             (32'(req_chan.height) <= (32'd1 << (MIN_SIDE_LOG2 + k)))) begin
            fits      = 1'b1;
            fit_class = CLASS_W'(k);
         end
      end
   end

   assign level_ok = (32'(req_chan.level) < NUM_CLASSES);

   always_comb begin
      push_entry.slot = req_chan.slot;
      push_entry.cls  = req_chan.level;
      if (req_chan.action == ACT_ALLOC) begin
         push_entry.cls = fits ? fit_class : '0;
         push_entry.cmd = fits ? CMD_ALLOC : CMD_TOO_LARGE;
      end else if (req_chan.action == ACT_FREE) begin
         push_entry.cmd = level_ok ? CMD_FREE : CMD_FREE_BAD_LEVEL;
      end else begin
         push_entry.cmd = level_ok ? CMD_QUERY : CMD_QUERY_BAD_LEVEL;
      end
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

// ----- design/scsa_queue.sv -----
// Short command queue between the front end and the back end.
module scsa_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  scsa_pkg::queue_entry_type push_entry,
   output logic                      pop_valid,
   input  logic                      pop,
   output scsa_pkg::queue_entry_type pop_entry
);
   import scsa_pkg::*;

   queue_entry_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (32'(count_ff) < QUEUE_DEPTH);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/scsa_back.sv -----
// Back end: occupancy memory, per-class counters, slot search and result register.
module scsa_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  scsa_pkg::queue_entry_type q_entry,
   output logic                      q_pop,
   scsa_rsp_if.source                rsp_chan
);
   import scsa_pkg::*;

   function automatic logic [BIT_IDX_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
      logic [BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!w[i]) begin
            idx = BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

   back_state_type        state_ff, state_in;
   queue_entry_type       cmd_ff;
   logic [WORD_IDX_W-1:0] word_ff, word_in;
   logic                  load_cmd;

   logic [COUNT_W-1:0]    used_ff [NUM_CLASSES];
   logic [COUNT_W-1:0]    live_ff [NUM_CLASSES];
   logic [ROWS-1:0]       row_valid_ff;

   logic [WORD_BITS-1:0]  mem [ROWS];
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  rd_valid_ff;
   logic [ROW_W-1:0]      row_addr;
   logic                  mem_re;
   logic                  mem_we;
   logic [WORD_BITS-1:0]  wdata;
   logic [WORD_BITS-1:0]  rd_word;

   logic                  rsp_valid_ff, rsp_valid_in;
   result_type            rsp_data_ff;
   result_type            res;
   logic                  load_res;
   logic                  out_free;

   logic                  alloc_commit;
   logic                  grow_commit;
   logic                  free_commit;

   logic [COUNT_W-1:0]    used_cur;
   logic [COUNT_W-1:0]    live_cur;
   logic                  zero_found;
   logic [BIT_IDX_W-1:0]  zero_idx;
   logic [SLOT_W-1:0]     found_slot;
   logic                  found_grows;
   logic                  free_bad;
   logic                  last_word;
   logic                  head_multi;

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign row_addr    = {cmd_ff.cls, word_ff};
   assign rd_word     = rd_valid_ff ? rd_data_ff : '0;
   assign used_cur    = used_ff[cmd_ff.cls];
   assign live_cur    = live_ff[cmd_ff.cls];
   assign zero_found  = ~&rd_word;
   assign zero_idx    = first_zero(rd_word);
   assign found_slot  = {word_ff, zero_idx};
   assign found_grows = ({1'b0, found_slot} == used_cur);
   assign free_bad    = ({1'b0, cmd_ff.slot} >= used_cur) ||
                        !rd_word[cmd_ff.slot[BIT_IDX_W-1:0]];
   assign last_word   = (word_ff == WORD_IDX_W'(WORDS_PER_CLASS - 1));
   assign head_multi  = (q_entry.cmd == CMD_ALLOC) || (q_entry.cmd == CMD_FREE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && head_multi) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            if (cmd_ff.cmd == CMD_ALLOC && !zero_found && !last_word) begin
               state_in = BK_READ;
            end else if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop        = 1'b0;
      load_cmd     = 1'b0;
      word_in      = word_ff;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      wdata        = rd_word;
      load_res     = 1'b0;
      alloc_commit = 1'b0;
      grow_commit  = 1'b0;
      free_commit  = 1'b0;
      res          = '{status: ST_OK, class_out: cmd_ff.cls, slot_out: '0,
                       grew: 1'b0, free_count: used_cur - live_cur};
      unique case (state_ff)
         BK_IDLE: begin
            res.class_out = q_entry.cls;
            res.free_count = '0;
            if (q_valid) begin
               if (head_multi) begin
                  q_pop    = 1'b1;
                  load_cmd = 1'b1;
                  word_in  = (q_entry.cmd == CMD_FREE) ?
                             q_entry.slot[SLOT_W-1 -: WORD_IDX_W] : '0;
               end else if (out_free) begin
                  q_pop    = 1'b1;
                  load_res = 1'b1;
                  priority case (q_entry.cmd)
                     CMD_TOO_LARGE: begin
                        res.status    = ST_TOO_LARGE;
                        res.class_out = '0;
                     end
                     CMD_FREE_BAD_LEVEL: res.status = ST_NOT_HELD;
                     CMD_QUERY: begin
                        res.free_count = used_ff[q_entry.cls] - live_ff[q_entry.cls];
                     end
                     default: res.status = ST_OK;
                  endcase
               end
            end
         end
         BK_READ: begin
            mem_re = 1'b1;
         end
         BK_CHECK: begin
            if (cmd_ff.cmd == CMD_ALLOC) begin
               if (zero_found) begin
                  res.slot_out   = found_slot;
                  res.grew       = found_grows;
                  res.free_count = used_cur - live_cur - COUNT_W'(!found_grows);
                  if (out_free) begin
                     load_res     = 1'b1;
                     mem_we       = 1'b1;
                     wdata        = rd_word | (WORD_BITS'(1) << zero_idx);
                     alloc_commit = 1'b1;
                     grow_commit  = found_grows;
                  end
               end else if (last_word) begin
                  res.status = ST_FULL;
                  load_res   = out_free;
               end else begin
                  word_in = word_ff + 1'b1;
               end
            end else begin
               load_res = out_free;
               if (free_bad) begin
                  res.status = ST_NOT_HELD;
               end else begin
                  res.free_count = used_cur - live_cur + 1'b1;
                  if (out_free) begin
                     mem_we      = 1'b1;
                     wdata       = rd_word & ~(WORD_BITS'(1) << cmd_ff.slot[BIT_IDX_W-1:0]);
                     free_commit = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = load_res || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         for (int k = 0; k < NUM_CLASSES; k++) begin
            used_ff[k] <= '0;
            live_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) begin
            row_valid_ff[row_addr] <= 1'b1;
         end
         if (grow_commit) begin
            used_ff[cmd_ff.cls] <= used_cur + 1'b1;
         end
         if (alloc_commit) begin
            live_ff[cmd_ff.cls] <= live_cur + 1'b1;
         end else if (free_commit) begin
            live_ff[cmd_ff.cls] <= live_cur - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_cmd) begin
         cmd_ff <= q_entry;
      end
      word_ff <= word_in;
      if (load_res) begin
         rsp_data_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[row_addr] <= wdata;
      end
      if (mem_re) begin
         rd_data_ff  <= mem[row_addr];
         rd_valid_ff <= row_valid_ff[row_addr];
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_data_ff.status;
   assign rsp_chan.class_out  = rsp_data_ff.class_out;
   assign rsp_chan.slot_out   = rsp_data_ff.slot_out;
   assign rsp_chan.grew       = rsp_data_ff.grew;
   assign rsp_chan.free_count = rsp_data_ff.free_count;

endmodule

// ----- design/size_class_slot_allocator.sv -----
// Size class slot allocator top level.
//
// Requests arrive as valid/ready beats on req_chan: allocate (width, height),
// free (level, slot) or query (level). Every request beat gives exactly one
// response beat on rsp_chan, in request order, with status, class, granted
// slot, a grew flag and the free count of the class after the operation.
// The front end picks the size class and decodes the command in the
// accepting cycle and writes it to a two-entry queue, so requests keep
// being taken while the back end works or the response waits.
// The back end keeps occupancy as 64-bit words in a memory, one read or
// write a cycle. Query and rejected requests are answered in the idle state;
// a free goes idle, read word, then check and write; an allocate repeats
// read and check per word scanned, up to the 4 words of its class.
// At reset the per-class lengths and counts clear and every memory row is
// marked empty through its row valid bit, so no clearing pass is needed and
// requests are taken as soon as reset is released.
// While the receiver holds rsp ready low the response register holds its
// beat; the back end waits with its next result and the queue fills, after
// which req ready drops.
module size_class_slot_allocator (
   input logic        clock,
   input logic        reset,
   scsa_req_if.sink   req_chan,
   scsa_rsp_if.source rsp_chan
);
   import scsa_pkg::*;

   logic            push_valid;
   logic            push_ready;
   queue_entry_type push_entry;
   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   scsa_front u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   scsa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_entry)
   );

   scsa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- bench/size_class_slot_allocator_test.sv -----
// Testbench for the size class slot allocator: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module size_class_slot_allocator_test;
   import scsa_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

   localparam int CYCLE_LIMIT       = 500000;
   localparam int LONG_HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES      = 40;
   localparam int PHASE_BEATS       = 500;
   localparam int MAX_REPORTS       = 10;

   logic clock = 1'b0;
   logic reset;

   scsa_req_if req_chan ();
   scsa_rsp_if rsp_chan ();

   size_class_slot_allocator uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bit slot_taken [NUM_CLASSES][SLOTS_PER_CLASS];
   int used_len   [NUM_CLASSES];
   int live_cnt   [NUM_CLASSES];

   result_type pending_results[$];
   result_type next_expected;

   int  mismatches    = 0;
   int  cycle_count   = 0;
   int  send_idle_pct = 15;
   int  recv_idle_pct = 47;
   bit  long_hold_req = 1'b0;
   logic long_hold;

   function automatic result_type compute_response(input logic [ACTION_W-1:0] act,
                                                   input logic [SIZE_W-1:0] w,
                                                   input logic [SIZE_W-1:0] h,
                                                   input logic [CLASS_W-1:0] lvl,
                                                   input logic [SLOT_W-1:0] sl);
      result_type r;
      int cls;
      int side;
      int i;
      r = '0;
      r.status = ST_OK;
      if (act == ACT_ALLOC) begin
         cls = NUM_CLASSES;
         for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
            side = 1 << (MIN_SIDE_LOG2 + k);
            if (w <= side && h <= side) cls = k;
         end
         if (cls == NUM_CLASSES) begin
            r.status = ST_TOO_LARGE;
         end else begin
            r.class_out = CLASS_W'(cls);
            i = 0;
            while (i < used_len[cls] && slot_taken[cls][i]) i++;
            if (i == SLOTS_PER_CLASS) begin
               r.status = ST_FULL;
            end else begin
               r.grew = (i == used_len[cls]);
               if (r.grew) used_len[cls]++;
               slot_taken[cls][i] = 1'b1;
               live_cnt[cls]++;
               r.slot_out = SLOT_W'(i);
            end
            r.free_count = COUNT_W'(used_len[cls] - live_cnt[cls]);
         end
      end else if (act == ACT_FREE) begin
         r.class_out = lvl;
         if (lvl >= NUM_CLASSES) begin
            r.status = ST_NOT_HELD;
         end else begin
            if (sl >= used_len[lvl] || !slot_taken[lvl][sl]) begin
               r.status = ST_NOT_HELD;
            end else begin
               slot_taken[lvl][sl] = 1'b0;
               live_cnt[lvl]--;
            end
            r.free_count = COUNT_W'(used_len[lvl] - live_cnt[lvl]);
         end
      end else begin
         r.class_out = lvl;
         if (lvl < NUM_CLASSES) r.free_count = COUNT_W'(used_len[lvl] - live_cnt[lvl]);
      end
      return r;
   endfunction

   task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [SIZE_W-1:0] w,
                            input logic [SIZE_W-1:0] h, input logic [CLASS_W-1:0] lvl,
                            input logic [SLOT_W-1:0] sl);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.width  <= w;
      req_chan.height <= h;
      req_chan.level  <= lvl;
      req_chan.slot   <= sl;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      pending_results.push_back(compute_response(act, w, h, lvl, sl));
   endtask

   task automatic alloc_beat(input int w, input int h);
      send_beat(ACT_ALLOC, SIZE_W'(w), SIZE_W'(h), CLASS_W'($urandom), SLOT_W'($urandom));
   endtask

   task automatic free_beat(input int lvl, input int sl);
      send_beat(ACT_FREE, SIZE_W'($urandom), SIZE_W'($urandom), CLASS_W'(lvl), SLOT_W'(sl));
   endtask

   task automatic query_beat(input logic [ACTION_W-1:0] act, input int lvl);
      send_beat(act, SIZE_W'($urandom), SIZE_W'($urandom), CLASS_W'(lvl), SLOT_W'($urandom));
   endtask

   task automatic test_size_edges();
      alloc_beat(0, 0);
      alloc_beat(8, 8);
      alloc_beat(9, 1);
      alloc_beat(1, 9);
      alloc_beat(16, 17);
      alloc_beat(16384, 16384);
      alloc_beat(16385, 0);
      alloc_beat(0, 16385);
      alloc_beat(32767, 32767);
   endtask

   task automatic test_free_and_query();
      free_beat(0, 0);
      free_beat(0, 0);
      alloc_beat(1, 1);
      free_beat(0, 200);
      free_beat(NUM_CLASSES, 0);
      free_beat(15, 255);
      query_beat(ACT_QUERY, 0);
      query_beat(ACT_QUERY, NUM_CLASSES - 1);
      query_beat(ACT_QUERY, NUM_CLASSES);
      query_beat(ACT_QUERY, 15);
      query_beat(ACT_SPARE, 1);
      query_beat(ACT_SPARE, 14);
   endtask

   task automatic test_class_full();
      for (int n = 0; n < SLOTS_PER_CLASS; n++) alloc_beat(16384, $urandom_range(0, 16384));
      free_beat(NUM_CLASSES - 1, 255);
      free_beat(NUM_CLASSES - 1, 170);
      free_beat(NUM_CLASSES - 1, 85);
      free_beat(NUM_CLASSES - 1, 85);
      for (int n = 0; n < 4; n++) alloc_beat(9000, 12000);
      query_beat(ACT_QUERY, NUM_CLASSES - 1);
   endtask

   task automatic test_response_stall();
      long_hold_req = 1'b1;
      for (int n = 0; n < 16; n++) begin
         if (n % 2 == 0) alloc_beat($urandom_range(0, 64), $urandom_range(0, 64));
         else query_beat(ACT_QUERY, $urandom_range(0, NUM_CLASSES - 1));
      end
   endtask

   task automatic test_random_traffic(input int beats);
      int pick;
      int k;
      int side;
      int start;
      int idx;
      for (int n = 0; n < beats; n++) begin
         pick = $urandom_range(0, 99);
         k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_CLASSES - 1)
                                         : $urandom_range(0, 3);
         if (pick < 40) begin
            side = 1 << (MIN_SIDE_LOG2 + k);
            if ($urandom_range(0, 9) == 0)
               alloc_beat($urandom_range(0, 32767), $urandom_range(0, 32767));
            else
               alloc_beat($urandom_range(0, side), $urandom_range(0, side));
         end else if (pick < 80) begin
            if ($urandom_range(0, 4) == 0) begin
               free_beat($urandom_range(0, 15), $urandom_range(0, 255));
            end else begin
               start = $urandom_range(0, SLOTS_PER_CLASS - 1);
               idx = -1;
               for (int j = 0; j < SLOTS_PER_CLASS; j++)
                  if (idx < 0 && slot_taken[k][(start + j) % SLOTS_PER_CLASS])
                     idx = (start + j) % SLOTS_PER_CLASS;
               if (idx < 0) idx = $urandom_range(0, 255);
               free_beat(k, idx);
            end
         end else if (pick < 95) begin
            query_beat(ACT_QUERY, $urandom_range(0, 15));
         end else begin
            query_beat(ACT_SPARE, $urandom_range(0, 15));
         end
      end
   endtask

   initial begin
      long_hold = 1'b0;
      wait (long_hold_req);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response beat: status %0d class %0d slot %0d",
                           rsp_chan.status, rsp_chan.class_out, rsp_chan.slot_out);
            end else begin
               next_expected = pending_results.pop_front();
               if (rsp_chan.status !== next_expected.status ||
                   rsp_chan.class_out !== next_expected.class_out ||
                   rsp_chan.slot_out !== next_expected.slot_out ||
                   rsp_chan.grew !== next_expected.grew ||
                   rsp_chan.free_count !== next_expected.free_count) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display({"mismatch: expected status %0d class %0d slot %0d grew %0d",
                               " free %0d, got status %0d class %0d slot %0d grew %0d",
                               " free %0d"},
                              next_expected.status, next_expected.class_out,
                              next_expected.slot_out, next_expected.grew,
                              next_expected.free_count, rsp_chan.status,
                              rsp_chan.class_out, rsp_chan.slot_out, rsp_chan.grew,
                              rsp_chan.free_count);
               end
            end
         end
         rsp_chan.ready <= !long_hold && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.action <= ACT_QUERY;
      req_chan.width  <= '0;
      req_chan.height <= '0;
      req_chan.level  <= '0;
      req_chan.slot   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_size_edges();
      test_free_and_query();
      test_class_full();
      test_random_traffic(PHASE_BEATS);

      send_idle_pct = 47;
      recv_idle_pct = 15;
      test_response_stall();
      test_random_traffic(PHASE_BEATS);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(PHASE_BEATS);

      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
design/scsa_pkg.sv
design/scsa_req_if.sv
design/scsa_front.sv
design/scsa_queue.sv
design/scsa_back.sv
design/size_class_slot_allocator.sv
bench/size_class_slot_allocator_test.sv
